@@ hw/rtl/ulebdec_pkg.sv @@
// Shared types and constants of the ULEB128 dictionary index decoder.
// Used by the front end, the queue, the back end and the top level.
package ulebdec_pkg;

    // Result status codes.
    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_PARTIAL = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DICT_TOTAL = 1'b0;
    localparam logic CFG_SPLIT      = 1'b1;

    localparam int          DICT_W        = 32;
    localparam int          SPLIT_W       = 13;
    localparam logic [12:0] SPLIT_RESET   = 13'd1000;

    // Seven-bit groups; ten of them reach bit 63, an eleventh zeroes the code.
    localparam int          GROUP_BITS    = 7;
    localparam int          GRP_W         = 4;
    localparam logic [3:0]  MAX_GROUPS    = 4'd10;

    // The divider retires this many quotient bits per clock.
    localparam int          DIV_STEP_BITS = 8;
    localparam int          DIV_CYCLES    = DICT_W / DIV_STEP_BITS;
    localparam int          DIV_CNT_W     = $clog2(DIV_CYCLES);

    // One classified index travelling from the front end to the back end.
    typedef struct packed {
        logic [1:0]        status;
        logic [DICT_W-1:0] idx;
        logic              fin;
    } t_qentry;

endpackage

@@ hw/rtl/ulebdec_queue.sv @@
// Short queue of classified indices between front end and back end.
// Depends on ulebdec_pkg for the entry type.
module ulebdec_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ulebdec_pkg::t_qentry i_entry,
    output logic                 o_not_full,
    input  logic                 i_pop,
    output logic                 o_not_empty,
    output ulebdec_pkg::t_qentry o_head
);
    import ulebdec_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qentry       r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_not_full  = (r_count != CW'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

@@ hw/rtl/ulebdec_front.sv @@
// Front end: gathers 7-bit groups of each code and classifies finished codes.
// Depends on ulebdec_pkg; feeds ulebdec_queue.
module ulebdec_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_last_byte,
    input  logic [ulebdec_pkg::DICT_W-1:0]  i_dict_total_size,
    input  logic [ulebdec_pkg::SPLIT_W-1:0] i_split_size,
    input  logic                       i_q_not_full,
    output logic                       o_push,
    output ulebdec_pkg::t_qentry       o_entry
);
    import ulebdec_pkg::*;

    // Only the low 32 bits of the code are kept; any set bit from 32 to 63 is
    // folded into a sticky flag, since such a code is always too large.
    logic [DICT_W-1:0] r_low;
    logic              r_hi;
    logic [GRP_W-1:0]  r_grp;
    logic              r_stopped;

    logic [DICT_W-1:0] n_low;
    logic              n_hi;
    logic [6:0]        grp;
    logic              more;
    logic              fire;
    logic              over;
    logic              val_zero;
    logic              too_big;
    logic              bad;

    assign grp        = i_data_byte[6:0];
    assign more       = i_data_byte[7];
    assign o_in_ready = i_q_not_full;
    assign fire       = i_in_valid && i_q_not_full;

    always_comb begin
        n_low = r_low;
        n_hi  = r_hi;
        case (r_grp)
            4'd0: n_low[6:0]   = grp;
            4'd1: n_low[13:7]  = grp;
            4'd2: n_low[20:14] = grp;
            4'd3: n_low[27:21] = grp;
            4'd4: begin
                n_low[31:28] = grp[3:0];
                n_hi         = r_hi | (|grp[6:4]);
            end
            4'd5, 4'd6, 4'd7, 4'd8: n_hi = r_hi | (|grp);
            // The group at bit 63 keeps only its lowest bit.
            4'd9: n_hi = r_hi | grp[0];
            default: begin
                n_low = r_low;
                n_hi  = r_hi;
            end
        endcase
    end

    assign over     = (r_grp == MAX_GROUPS);
    assign val_zero = over || (!n_hi && (n_low == '0));
    assign too_big  = !over && (n_hi || (n_low > i_dict_total_size));
    assign bad      = val_zero || too_big || (i_split_size == '0);

    assign o_push = fire && !r_stopped && (i_last_byte || !more);

    always_comb begin
        if (more) begin
            o_entry.status = ST_PARTIAL;
            o_entry.idx    = '0;
            o_entry.fin    = 1'b1;
        end else if (bad) begin
            o_entry.status = ST_BAD;
            o_entry.idx    = '0;
            o_entry.fin    = 1'b1;
        end else begin
            o_entry.status = ST_VALID;
            o_entry.idx    = n_low - 1'b1;
            o_entry.fin    = i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low     <= '0;
            r_hi      <= 1'b0;
            r_grp     <= '0;
            r_stopped <= 1'b0;
        end else if (fire) begin
            if (r_stopped) begin
                if (i_last_byte) begin
                    r_stopped <= 1'b0;
                    r_low     <= '0;
                    r_hi      <= 1'b0;
                    r_grp     <= '0;
                end
            end else if (more && !i_last_byte) begin
                r_low <= n_low;
                r_hi  <= n_hi;
                r_grp <= over ? r_grp : r_grp + 1'b1;
            end else begin
                r_low <= '0;
                r_hi  <= 1'b0;
                r_grp <= '0;
                if (!more && bad && !i_last_byte) begin
                    r_stopped <= 1'b1;
                end
            end
        end
    end

endmodule

@@ hw/rtl/ulebdec_back.sv @@
// Back end: divides valid indices by the split size and holds the result word.
// Depends on ulebdec_pkg; drains ulebdec_queue.
module ulebdec_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ulebdec_pkg::SPLIT_W-1:0] i_split_size,
    input  logic                            i_q_not_empty,
    input  ulebdec_pkg::t_qentry            i_head,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_status,
    output logic [ulebdec_pkg::DICT_W-1:0]  o_block_number,
    output logic [ulebdec_pkg::SPLIT_W-1:0] o_entry_position,
    output logic                            o_final_res
);
    import ulebdec_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DICT_W-1:0]    r_quo;
    logic [SPLIT_W-1:0]   r_rem;
    logic                 r_fin;

    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic [DICT_W-1:0]    r_block;
    logic [SPLIT_W-1:0]   r_pos;
    logic                 r_fin_out;

    logic [DICT_W-1:0]    n_quo;
    logic [SPLIT_W-1:0]   n_rem;
    logic                 out_free;
    logic                 load_div;
    logic                 load_err;
    logic                 start;

    // Restoring division, eight quotient bits per clock.
    always_comb begin
        logic [SPLIT_W:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            trial = {n_rem, n_quo[DICT_W-1]};
            n_quo = {n_quo[DICT_W-2:0], 1'b0};
            if (trial >= {1'b0, i_split_size}) begin
                trial    = trial - {1'b0, i_split_size};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[SPLIT_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign load_div = r_busy && r_done && out_free;
    // A new division may start in the cycle the previous quotient is unloaded.
    assign start    = i_q_not_empty && (i_head.status == ST_VALID) && (!r_busy || load_div);
    assign load_err = !r_busy && i_q_not_empty && (i_head.status != ST_VALID) && out_free;
    assign o_pop    = start || load_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (load_div) begin
                r_busy <= 1'b0;
            end else if (r_busy && !r_done) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_done <= 1'b1;
                end
            end
            if (load_div || load_err) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_quo <= i_head.idx;
            r_rem <= '0;
            r_fin <= i_head.fin;
        end else if (r_busy && !r_done) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (load_div) begin
            r_status  <= ST_VALID;
            r_block   <= r_quo + 1'b1;
            r_pos     <= r_rem;
            r_fin_out <= r_fin;
        end else if (load_err) begin
            r_status  <= i_head.status;
            r_block   <= '0;
            r_pos     <= '0;
            r_fin_out <= i_head.fin;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_block_number   = r_block;
    assign o_entry_position = r_pos;
    assign o_final_res      = r_fin_out;

endmodule

@@ hw/rtl/uleb128_dictionary_index_decoder.sv @@
// Top level of the ULEB128 dictionary index decoder: configuration registers,
// front end, queue and back end. Depends on ulebdec_pkg and the ulebdec modules.
//
// Input channel: one encoded byte per word (i_data_byte, i_last_byte) under
// i_in_valid / o_in_ready. Bit 7 of a byte means more groups follow; the
// last-byte mark closes the string. Output channel: at most one result word
// per byte (status, block number, entry position, final flag) under
// o_out_valid / i_out_ready.
// The front end takes one byte per clock while the queue has room. A byte
// that only continues a code produces nothing. A finished code is classified
// at once; an error or a partial-code end goes through the queue to the
// output register. A valid index goes through the back-end divider, which
// retires eight quotient bits per clock; it starts a new division only once
// the previous quotient is unloaded into the output register. The divider
// sets the sustained rate for strings of one-byte codes.
// When the receiver stalls, the result word is held in the output register,
// the divider keeps its finished quotient, and the queue fills; the input
// then stalls through o_in_ready.
// The synchronous reset empties the queue, clears the partial code and the
// stop mark, and loads a dictionary size of 0 and a split size of 1000.
// Configuration must be written only while no byte is in flight.
module uleb128_dictionary_index_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_block_number,
    output logic [12:0] o_entry_position,
    output logic        o_final_res
);
    import ulebdec_pkg::*;

    logic [DICT_W-1:0]  r_dict_total_size;
    logic [SPLIT_W-1:0] r_split_size;

    logic    q_not_full;
    logic    q_not_empty;
    logic    push;
    logic    pop;
    t_qentry push_entry;
    t_qentry head_entry;

    // Configuration registers; a write is taken in the cycle it is presented.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dict_total_size <= '0;
            r_split_size      <= SPLIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DICT_TOTAL: r_dict_total_size <= i_cfg_wdata;
                CFG_SPLIT:      r_split_size      <= i_cfg_wdata[SPLIT_W-1:0];
                default:        r_split_size      <= r_split_size;
            endcase
        end
    end

    // The front end gathers groups and classifies each finished code.
    ulebdec_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .i_dict_total_size (r_dict_total_size),
        .i_split_size      (r_split_size),
        .i_q_not_full      (q_not_full),
        .o_push            (push),
        .o_entry           (push_entry)
    );

    // The queue decouples byte intake from the divider.
    ulebdec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_entry     (push_entry),
        .o_not_full  (q_not_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_head      (head_entry)
    );

    // The back end splits valid indices and owns the output register.
    ulebdec_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_split_size     (r_split_size),
        .i_q_not_empty    (q_not_empty),
        .i_head           (head_entry),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_block_number   (o_block_number),
        .o_entry_position (o_entry_position),
        .o_final_res      (o_final_res)
    );

endmodule

@@ hw/rtl/ulebdec_checker.sv @@
// Port-level checks on the ULEB128 dictionary index decoder.
// Depends on ulebdec_pkg; bound to the top level below.
module ulebdec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [31:0] o_block_number,
    input logic [12:0] o_entry_position,
    input logic        o_final_res
);
    import ulebdec_pkg::*;

    // No result word is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result word offered after reset");

    // Only the three defined status codes ever appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_VALID || o_status == ST_BAD
                         || o_status == ST_PARTIAL))
        else $error("undefined status code");

    // Error words carry zero fields and end the string.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_VALID)
            |-> (o_block_number == '0 && o_entry_position == '0 && o_final_res))
        else $error("malformed error word");

    // Sub-dictionaries are counted from one.
    a_block_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_VALID) |-> (o_block_number != '0))
        else $error("valid word with block number zero");

    // A stalled word stays on the port unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_block_number) && $stable(o_entry_position)))
        else $error("stalled result word changed");

endmodule

bind uleb128_dictionary_index_decoder ulebdec_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_block_number   (o_block_number),
    .o_entry_position (o_entry_position),
    .o_final_res      (o_final_res)
);
